[hdl/cae_pkg.sv]
// ----------------------------------------------------------------------------
// cae_pkg
// Shared widths, constants, command codes and the controller/datapath
// interface types for the AGM complete elliptic integral engine.
// ----------------------------------------------------------------------------
package cae_pkg;

    // Fixed-point layout, fraction bits of a, b and c.
    localparam int FRAC_BITS = 32;
    localparam int VAL_W     = FRAC_BITS + 1;      // a, b, c, d up to 1.0
    localparam int SUM_W     = VAL_W + 1;          // a + b
    localparam int MUL_W     = SUM_W;              // multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;          // multiplier product width
    localparam int RAD_W     = 2 * FRAC_BITS + 2;  // square root radicand width
    localparam int ROOT_W    = RAD_W / 2;          // square root result width
    localparam int DIVN_W    = 67;                 // dividend width
    localparam int DIVD_W    = SUM_W;              // divisor width
    localparam int ACC_W     = VAL_W + 64;         // c * pi accumulator width

    // Field widths.
    localparam int K_IN_W = 32;
    localparam int KIND1_W = 36;
    localparam int KIND2_W = 34;
    localparam int ITER_W  = 5;
    localparam int THR_W   = 16;
    localparam int STEP_W  = 6;

    localparam logic [63:0]      PI_Q62     = 64'hC90FDAA22168C234;
    localparam logic [THR_W-1:0] THR_RESET  = 16'd1160;

    // Datapath commands.
    localparam int CMD_W = 5;
    localparam logic [CMD_W-1:0] CMD_NOP      = 5'd0;
    localparam logic [CMD_W-1:0] CMD_MUL_KK   = 5'd1;
    localparam logic [CMD_W-1:0] CMD_SQRT_OM  = 5'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_A0  = 5'd3;
    localparam logic [CMD_W-1:0] CMD_MUL_SS   = 5'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD_C0  = 5'd5;
    localparam logic [CMD_W-1:0] CMD_MUL_AB   = 5'd6;
    localparam logic [CMD_W-1:0] CMD_SQRT_AB  = 5'd7;
    localparam logic [CMD_W-1:0] CMD_STEP_AB  = 5'd8;
    localparam logic [CMD_W-1:0] CMD_DIFF     = 5'd9;
    localparam logic [CMD_W-1:0] CMD_MUL_DD   = 5'd10;
    localparam logic [CMD_W-1:0] CMD_UPD_C    = 5'd11;
    localparam logic [CMD_W-1:0] CMD_MUL_TA   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_DIV_K    = 5'd13;
    localparam logic [CMD_W-1:0] CMD_SAVE_K   = 5'd14;
    localparam logic [CMD_W-1:0] CMD_MUL_CPL  = 5'd15;
    localparam logic [CMD_W-1:0] CMD_MUL_CPH  = 5'd16;
    localparam logic [CMD_W-1:0] CMD_SUM_EN   = 5'd17;
    localparam logic [CMD_W-1:0] CMD_DIV_E    = 5'd18;
    localparam logic [CMD_W-1:0] CMD_SAVE_OUT = 5'd19;

    // Command from controller to datapath.
    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [STEP_W-1:0] step;   // mean step index, or the final step count
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic converged;
    } t_stat;

endpackage

[hdl/cae_sqrt.sv]
// ----------------------------------------------------------------------------
// cae_sqrt
// Bit-serial integer square root: floor(sqrt(radicand)), one root bit per
// cycle; done is set at the same edge that registers the last root bit.
// ----------------------------------------------------------------------------
module cae_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cae_pkg::RAD_W-1:0]   i_radicand,
    output logic                        o_done,
    output logic [cae_pkg::ROOT_W-1:0]  o_root
);

    localparam int REM_W = cae_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(cae_pkg::ROOT_W + 1);

    logic [cae_pkg::RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [cae_pkg::ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [REM_W-1:0]           rem_sh;
    logic [REM_W-1:0]           trial;
    logic                       fits;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[cae_pkg::RAD_W-1 -: 2]};
        trial  = REM_W'({r_root, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(cae_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[cae_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[cae_pkg::ROOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[hdl/cae_div.sv]
// ----------------------------------------------------------------------------
// cae_div
// Bit-serial restoring divider: floor(numerator / denominator), one
// quotient bit per cycle; done is set at the same edge that registers the last bit.
// ----------------------------------------------------------------------------
module cae_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cae_pkg::DIVN_W-1:0]  i_num,
    input  logic [cae_pkg::DIVD_W-1:0]  i_den,
    output logic                        o_done,
    output logic [cae_pkg::DIVN_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(cae_pkg::DIVN_W + 1);

    logic [cae_pkg::DIVN_W-1:0] r_q;
    logic [cae_pkg::DIVD_W-1:0] r_den;
    logic [cae_pkg::DIVD_W-1:0] r_rem;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [cae_pkg::DIVD_W:0]   rem_sh;
    logic                       fits;

    // Shift in the next dividend bit and compare.
    always_comb begin
        rem_sh = {r_rem, r_q[cae_pkg::DIVN_W-1]};
        fits   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(cae_pkg::DIVN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend register fills with quotient bits as it empties.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[cae_pkg::DIVN_W-2:0], fits};
            r_rem <= fits ? cae_pkg::DIVD_W'(rem_sh - {1'b0, r_den})
                          : cae_pkg::DIVD_W'(rem_sh);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[hdl/cae_datapath.sv]
// ----------------------------------------------------------------------------
// cae_datapath
// Mean registers a, b, c, d, one shared multiplier, the square root and
// divider units, and the result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module cae_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cae_pkg::t_cmd                 i_cmd,
    input  logic [cae_pkg::K_IN_W-1:0]    i_k_modulus,
    input  logic [cae_pkg::THR_W-1:0]     i_threshold,
    output cae_pkg::t_stat                o_stat,
    output logic [cae_pkg::KIND1_W-1:0]   o_first_kind,
    output logic [cae_pkg::KIND2_W-1:0]   o_second_kind,
    output logic [cae_pkg::ITER_W-1:0]    o_iterations_used
);

    logic [cae_pkg::PROD_W-1:0]  r_p;
    logic [cae_pkg::VAL_W-1:0]   r_a;
    logic [cae_pkg::VAL_W-1:0]   r_b;
    logic [cae_pkg::VAL_W-1:0]   r_c;
    logic [cae_pkg::VAL_W-1:0]   r_d;
    logic [cae_pkg::ACC_W-1:0]   r_acc;
    logic [cae_pkg::KIND1_W-1:0] r_k_res;
    logic [cae_pkg::KIND1_W-1:0] r_out_k;
    logic [cae_pkg::KIND2_W-1:0] r_out_e;
    logic [cae_pkg::ITER_W-1:0]  r_out_it;

    logic [cae_pkg::MUL_W-1:0]   mul_x;
    logic [cae_pkg::MUL_W-1:0]   mul_y;
    logic                        mul_en;
    logic [cae_pkg::SUM_W-1:0]   sum_ab;
    logic [cae_pkg::RAD_W-1:0]   om;
    logic                        sqrt_start;
    logic [cae_pkg::RAD_W-1:0]   sqrt_rad;
    logic                        sqrt_done;
    logic [cae_pkg::ROOT_W-1:0]  sqrt_root;
    logic                        div_start;
    logic [cae_pkg::DIVN_W-1:0]  div_num;
    logic                        div_done;
    logic [cae_pkg::DIVN_W-1:0]  div_quot;
    logic [cae_pkg::VAL_W:0]     sq;
    logic [63:0]                 term;
    logic [cae_pkg::PROD_W-1:0]  dshift;

    assign sum_ab = {1'b0, r_a} + {1'b0, r_b};
    assign om     = {2'b01, 64'd0} - {2'b00, r_p[63:0]};

    // Multiplier operand selection.
    always_comb begin
        mul_x  = '0;
        mul_y  = '0;
        mul_en = 1'b1;
        case (i_cmd.op)
            cae_pkg::CMD_MUL_KK: begin
                mul_x = cae_pkg::MUL_W'(i_k_modulus);
                mul_y = cae_pkg::MUL_W'(i_k_modulus);
            end
            cae_pkg::CMD_MUL_SS: begin
                mul_x = sum_ab;
                mul_y = sum_ab;
            end
            cae_pkg::CMD_MUL_AB: begin
                mul_x = cae_pkg::MUL_W'(r_a);
                mul_y = cae_pkg::MUL_W'(r_b);
            end
            cae_pkg::CMD_MUL_DD: begin
                mul_x = cae_pkg::MUL_W'(r_d);
                mul_y = cae_pkg::MUL_W'(r_d);
            end
            cae_pkg::CMD_MUL_TA: begin
                mul_x = cae_pkg::MUL_W'(i_threshold);
                mul_y = cae_pkg::MUL_W'(r_a);
            end
            cae_pkg::CMD_MUL_CPL: begin
                mul_x = cae_pkg::MUL_W'(r_c);
                mul_y = cae_pkg::MUL_W'(cae_pkg::PI_Q62[31:0]);
            end
            cae_pkg::CMD_MUL_CPH: begin
                mul_x = cae_pkg::MUL_W'(r_c);
                mul_y = cae_pkg::MUL_W'(cae_pkg::PI_Q62[63:32]);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_p <= mul_x * mul_y;
        end
    end

    // Shared square root for the start value and for each geometric mean.
    assign sqrt_start = (i_cmd.op == cae_pkg::CMD_SQRT_OM) ||
                        (i_cmd.op == cae_pkg::CMD_SQRT_AB);
    assign sqrt_rad   = (i_cmd.op == cae_pkg::CMD_SQRT_OM) ? om
                                                          : r_p[cae_pkg::RAD_W-1:0];

    cae_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (sqrt_rad),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // Shared divider for K and for E, both over a + b.
    assign div_start = (i_cmd.op == cae_pkg::CMD_DIV_K) ||
                       (i_cmd.op == cae_pkg::CMD_DIV_E);
    assign div_num   = (i_cmd.op == cae_pkg::CMD_DIV_K)
                       ? {1'b0, cae_pkg::PI_Q62, 2'b00}
                       : r_acc[cae_pkg::ACC_W-1:30];

    cae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (sum_ab),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Correction term for c: the truncated square, scaled by 2^(m-1).
    always_comb begin
        sq = r_p[65:32];
        if (i_cmd.step == '0) begin
            term = 64'(sq >> 1);
        end else begin
            term = 64'(sq) << (i_cmd.step - 1'b1);
        end
    end

    // Mean registers and result accumulation.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cae_pkg::CMD_LOAD_A0: begin
                r_a <= sqrt_root;
                r_b <= cae_pkg::VAL_W'(1) << cae_pkg::FRAC_BITS;
            end
            cae_pkg::CMD_LOAD_C0: r_c <= r_p[cae_pkg::FRAC_BITS + 2 +: cae_pkg::VAL_W];
            cae_pkg::CMD_STEP_AB: begin
                r_a <= sum_ab[cae_pkg::SUM_W-1:1];
                r_b <= sqrt_root;
            end
            cae_pkg::CMD_DIFF: r_d <= (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);
            cae_pkg::CMD_UPD_C: begin
                r_c <= (64'(r_c) > term) ? cae_pkg::VAL_W'(64'(r_c) - term) : '0;
            end
            cae_pkg::CMD_SAVE_K: begin
                r_k_res <= (div_quot[cae_pkg::DIVN_W-1:cae_pkg::KIND1_W] != '0)
                           ? '1 : div_quot[cae_pkg::KIND1_W-1:0];
            end
            cae_pkg::CMD_MUL_CPH: r_acc <= cae_pkg::ACC_W'(r_p);
            cae_pkg::CMD_SUM_EN:  r_acc <= r_acc + (cae_pkg::ACC_W'(r_p) << 32);
            cae_pkg::CMD_SAVE_OUT: begin
                r_out_k  <= r_k_res;
                r_out_e  <= (div_quot[cae_pkg::DIVN_W-1:cae_pkg::KIND2_W] != '0)
                            ? '1 : div_quot[cae_pkg::KIND2_W-1:0];
                r_out_it <= i_cmd.step[cae_pkg::ITER_W-1:0];
            end
            default: ;
        endcase
    end

    // Convergence: |a-b| * 2^32 < threshold * a.
    assign dshift = cae_pkg::PROD_W'({r_d, 32'd0});

    assign o_stat.sqrt_done = sqrt_done;
    assign o_stat.div_done  = div_done;
    assign o_stat.converged = (dshift < r_p);

    assign o_first_kind      = r_out_k;
    assign o_second_kind     = r_out_e;
    assign o_iterations_used = r_out_it;

endmodule

[hdl/cae_ctrl.sv]
// ----------------------------------------------------------------------------
// cae_ctrl
// Sequencer for one modulus: start values, the mean steps with the early
// stop test, the two divisions, and the result register handshake.
// ----------------------------------------------------------------------------
module cae_ctrl #(
    parameter int MAX_ITERATIONS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  cae_pkg::t_stat i_stat,
    output cae_pkg::t_cmd  o_cmd
);

    localparam int M_W = $clog2(MAX_ITERATIONS + 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_OM   = 5'd1;
    localparam logic [4:0] S_SQ0W = 5'd2;
    localparam logic [4:0] S_SS   = 5'd3;
    localparam logic [4:0] S_C0   = 5'd4;
    localparam logic [4:0] S_AB   = 5'd5;
    localparam logic [4:0] S_RT   = 5'd6;
    localparam logic [4:0] S_RTW  = 5'd7;
    localparam logic [4:0] S_DIFF = 5'd8;
    localparam logic [4:0] S_DD   = 5'd9;
    localparam logic [4:0] S_CU   = 5'd10;
    localparam logic [4:0] S_TA   = 5'd11;
    localparam logic [4:0] S_CV   = 5'd12;
    localparam logic [4:0] S_DK   = 5'd13;
    localparam logic [4:0] S_DKW  = 5'd14;
    localparam logic [4:0] S_CPL  = 5'd15;
    localparam logic [4:0] S_CPH  = 5'd16;
    localparam logic [4:0] S_SUM  = 5'd17;
    localparam logic [4:0] S_DE   = 5'd18;
    localparam logic [4:0] S_DEW  = 5'd19;
    localparam logic [4:0] S_FIN  = 5'd20;

    logic [4:0]     r_state;
    logic [4:0]     n_state;
    logic [M_W-1:0] r_m;
    logic [M_W-1:0] n_m;
    logic           r_out_valid;
    logic           n_out_valid;
    logic           accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and command.
    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = cae_pkg::CMD_NOP;
        o_cmd.step  = cae_pkg::STEP_W'(r_m);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = cae_pkg::CMD_MUL_KK;
                    n_state  = S_OM;
                end
            end
            S_OM: begin
                o_cmd.op = cae_pkg::CMD_SQRT_OM;
                n_state  = S_SQ0W;
            end
            S_SQ0W: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.op = cae_pkg::CMD_LOAD_A0;
                    n_state  = S_SS;
                end
            end
            S_SS: begin
                o_cmd.op = cae_pkg::CMD_MUL_SS;
                n_state  = S_C0;
            end
            S_C0: begin
                o_cmd.op = cae_pkg::CMD_LOAD_C0;
                n_m      = '0;
                n_state  = S_AB;
            end
            S_AB: begin
                o_cmd.op = cae_pkg::CMD_MUL_AB;
                n_state  = S_RT;
            end
            S_RT: begin
                o_cmd.op = cae_pkg::CMD_SQRT_AB;
                n_state  = S_RTW;
            end
            S_RTW: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.op = cae_pkg::CMD_STEP_AB;
                    n_state  = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.op = cae_pkg::CMD_DIFF;
                n_state  = S_DD;
            end
            S_DD: begin
                o_cmd.op = cae_pkg::CMD_MUL_DD;
                n_state  = S_CU;
            end
            S_CU: begin
                o_cmd.op = cae_pkg::CMD_UPD_C;
                n_state  = S_TA;
            end
            S_TA: begin
                o_cmd.op = cae_pkg::CMD_MUL_TA;
                n_state  = S_CV;
            end
            // Count the step; stop on convergence or at the step limit.
            S_CV: begin
                n_m = r_m + 1'b1;
                if (i_stat.converged || (r_m == M_W'(MAX_ITERATIONS - 1))) begin
                    n_state = S_DK;
                end else begin
                    n_state = S_AB;
                end
            end
            S_DK: begin
                o_cmd.op = cae_pkg::CMD_DIV_K;
                n_state  = S_DKW;
            end
            S_DKW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = cae_pkg::CMD_SAVE_K;
                    n_state  = S_CPL;
                end
            end
            S_CPL: begin
                o_cmd.op = cae_pkg::CMD_MUL_CPL;
                n_state  = S_CPH;
            end
            S_CPH: begin
                o_cmd.op = cae_pkg::CMD_MUL_CPH;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = cae_pkg::CMD_SUM_EN;
                n_state  = S_DE;
            end
            S_DE: begin
                o_cmd.op = cae_pkg::CMD_DIV_E;
                n_state  = S_DEW;
            end
            S_DEW: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end
            end
            // Load the result register once it is free or being emptied.
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = cae_pkg::CMD_SAVE_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_m         <= n_m;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[hdl/complete_elliptic_integrals_agm.sv]
// ----------------------------------------------------------------------------
// complete_elliptic_integrals_agm
// Complete elliptic integrals K(k) and E(k) by the arithmetic-geometric mean
// in fixed point, with a programmable relative stop threshold.
//
//   Channel   Dir  Request carries
//   s_t*      in   k_modulus (Q0.32)
//   m_t*      out  first_kind (Q4.32), second_kind (Q2.32), iterations_used
//   APB       in   convergence_threshold at byte address 0
//
// One request runs the start values, N mean steps (at most MAX_ITERATIONS,
// 16 by default) and two divisions. Each mean step waits on the bit-serial
// square root (33 root bits), and the bit-serial divider (67 quotient bits)
// runs twice.
// A new request is taken once the previous one has reached the result
// register, even while that result still waits for i_m_tready.
// Reset is synchronous and active low; the threshold resets to 1160.
// ----------------------------------------------------------------------------
module complete_elliptic_integrals_agm #(
    parameter int MAX_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // [31:0] k_modulus
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,    // [35:0] first_kind, [69:36] second_kind,
                                      // [74:70] iterations_used, [79:75] zero
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_THRESHOLD = 1'b0;

    logic [cae_pkg::THR_W-1:0]   r_threshold;
    cae_pkg::t_cmd               cmd;
    cae_pkg::t_stat              stat;
    logic [cae_pkg::KIND1_W-1:0] first_kind;
    logic [cae_pkg::KIND2_W-1:0] second_kind;
    logic [cae_pkg::ITER_W-1:0]  iterations_used;

    // Threshold register.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= cae_pkg::THR_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_THRESHOLD)) begin
            r_threshold <= pwdata[cae_pkg::THR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(r_threshold) : 32'd0;

    cae_ctrl #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cae_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_k_modulus       (i_s_tdata),
        .i_threshold       (r_threshold),
        .o_stat            (stat),
        .o_first_kind      (first_kind),
        .o_second_kind     (second_kind),
        .o_iterations_used (iterations_used)
    );

    assign o_m_tdata = {5'd0, iterations_used, second_kind, first_kind};

endmodule
